/* design/arpr_pkg.sv */
package arpr_pkg;

   // configuration register indexes
   localparam logic CSR_MY_IP  = 1'b0;
   localparam logic CSR_MY_MAC = 1'b1;

   // result kinds
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_LEARN = 1'b1;

   // frame offsets
   localparam logic [5:0] POS_PEER_MAC  = 6'd6;
   localparam logic [5:0] POS_TYPE_HI   = 6'd12;
   localparam logic [5:0] POS_TYPE_LO   = 6'd13;
   localparam logic [5:0] POS_OPCODE    = 6'd21;
   localparam logic [5:0] POS_SHA       = 6'd22;
   localparam logic [5:0] POS_SPA       = 6'd28;
   localparam logic [5:0] POS_THA       = 6'd32;
   localparam logic [5:0] POS_TPA       = 6'd38;
   localparam logic [5:0] POS_END       = 6'd42;
   localparam logic [5:0] POS_LAST      = 6'd41;
   localparam logic [5:0] POS_MAX       = 6'd63;

   // protocol constants
   localparam logic [7:0] ETHTYPE_HI  = 8'h08;
   localparam logic [7:0] ETHTYPE_LO  = 8'h06;
   localparam logic [7:0] HTYPE_HI    = 8'h00;
   localparam logic [7:0] HTYPE_LO    = 8'h01;
   localparam logic [7:0] PTYPE_HI    = 8'h08;
   localparam logic [7:0] PTYPE_LO    = 8'h00;
   localparam logic [7:0] HLEN        = 8'h06;
   localparam logic [7:0] PLEN        = 8'h04;
   localparam logic [7:0] OPCODE_HI   = 8'h00;
   localparam logic [7:0] OP_REQUEST  = 8'h01;
   localparam logic [7:0] OP_REPLY    = 8'h02;

   // frame-end event handed from parser to transmitter
   typedef struct packed {
      logic        valid;
      logic        learn;
      logic [47:0] peer_mac;
      logic [47:0] sha;
      logic [31:0] spa;
   } event_type;

   // byte k of a MAC, most significant byte first on the wire
   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
      logic [47:0] s;
      s = mac >> {3'd5 - k, 3'b000};
      return s[7:0];
   endfunction

   // byte k of an IPv4 address, bits 7:0 first on the wire
   function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
      logic [31:0] s;
      s = ip >> {k, 3'b000};
      return s[7:0];
   endfunction

endpackage

/* design/arpr_parser.sv */
module arpr_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic                frame_end,
   input  logic [31:0]         my_ip,
   output arpr_pkg::event_type evt
);

   logic [5:0]  pos_ff, pos_in;
   logic        is_arp_ff, is_arp_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [47:0] peer_ff, peer_in;
   logic [47:0] sha_ff, sha_in;
   logic [31:0] spa_ff, spa_in;
   logic        tgt_ff, tgt_in;
   logic        tgt_now;
   logic [5:0]  rel;
   logic        fire;

   // field capture for the request byte at the current position
   always_comb begin
      pos_in    = pos_ff;
      is_arp_in = is_arp_ff;
      opcode_in = opcode_ff;
      peer_in   = peer_ff;
      sha_in    = sha_ff;
      spa_in    = spa_ff;
      tgt_in    = tgt_ff;
      rel       = 6'd0;
      if (pos_ff >= arpr_pkg::POS_PEER_MAC && pos_ff < arpr_pkg::POS_TYPE_HI) begin
         peer_in = {peer_ff[39:0], rx_byte};
      end else if (pos_ff == arpr_pkg::POS_TYPE_HI) begin
         is_arp_in = (rx_byte == arpr_pkg::ETHTYPE_HI);
      end else if (pos_ff == arpr_pkg::POS_TYPE_LO) begin
         is_arp_in = is_arp_ff && (rx_byte == arpr_pkg::ETHTYPE_LO);
      end else if (pos_ff == arpr_pkg::POS_OPCODE) begin
         opcode_in = rx_byte;
      end else if (pos_ff >= arpr_pkg::POS_SHA && pos_ff < arpr_pkg::POS_SPA) begin
         sha_in = {sha_ff[39:0], rx_byte};
      end else if (pos_ff >= arpr_pkg::POS_SPA && pos_ff < arpr_pkg::POS_THA) begin
         rel = pos_ff - arpr_pkg::POS_SPA;
         unique case (rel[1:0])
            2'd0: spa_in[7:0]   = rx_byte;
            2'd1: spa_in[15:8]  = rx_byte;
            2'd2: spa_in[23:16] = rx_byte;
            2'd3: spa_in[31:24] = rx_byte;
         endcase
      end else if (pos_ff >= arpr_pkg::POS_TPA && pos_ff < arpr_pkg::POS_END) begin
         rel = pos_ff - arpr_pkg::POS_TPA;
         if (arpr_pkg::ip_byte(my_ip, rel[1:0]) != rx_byte) begin
            tgt_in = 1'b0;
         end
      end

      // target match including the current byte, before the frame restart
      tgt_now = tgt_in;

      if (frame_end) begin
         pos_in    = 6'd0;
         is_arp_in = 1'b0;
         tgt_in    = 1'b1;
      end else if (pos_ff != arpr_pkg::POS_MAX) begin
         pos_in = pos_ff + 6'd1;
      end
   end

   // frame-end decision; captures are complete by the last reply-sized byte
   always_comb begin
      fire = 1'b0;
      if (pos_ff >= arpr_pkg::POS_LAST && is_arp_ff) begin
         if (opcode_ff == arpr_pkg::OP_REPLY) begin
            fire = 1'b1;
         end else if (opcode_ff == arpr_pkg::OP_REQUEST) begin
            fire = tgt_now && (my_ip != 32'd0);
         end
      end
      evt.valid    = accept && frame_end && fire;
      evt.learn    = (opcode_ff == arpr_pkg::OP_REPLY);
      evt.peer_mac = peer_ff;
      evt.sha      = sha_ff;
      evt.spa      = spa_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 6'd0;
         is_arp_ff <= 1'b0;
         opcode_ff <= 8'd0;
         peer_ff   <= 48'd0;
         sha_ff    <= 48'd0;
         spa_ff    <= 32'd0;
         tgt_ff    <= 1'b1;
      end else if (accept) begin
         pos_ff    <= pos_in;
         is_arp_ff <= is_arp_in;
         opcode_ff <= opcode_in;
         peer_ff   <= peer_in;
         sha_ff    <= sha_in;
         spa_ff    <= spa_in;
         tgt_ff    <= tgt_in;
      end
   end

   // frame end always rearms the parser
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> pos_ff == 6'd0 && tgt_ff && !is_arp_ff)
      else $error("parser not rearmed after frame end");

   // an event needs an ARP ethertype and a long enough frame
   a_evt_arp: assert property (@(posedge clock) disable iff (reset)
      evt.valid |-> is_arp_ff && pos_ff >= arpr_pkg::POS_LAST)
      else $error("event from non-ARP or short frame");

   // position saturates instead of wrapping
   a_sat: assert property (@(posedge clock) disable iff (reset)
      accept && !frame_end && pos_ff == arpr_pkg::POS_MAX |=> pos_ff == arpr_pkg::POS_MAX)
      else $error("byte position wrapped");

endmodule

/* design/arpr_tx.sv */
module arpr_tx (
   input  logic                clock,
   input  logic                reset,
   input  arpr_pkg::event_type evt,
   input  logic [31:0]         my_ip,
   input  logic [47:0]         my_mac,
   output logic                busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_tx_last,
   output logic [31:0]         rsp_learned_ip,
   output logic [47:0]         rsp_learned_mac
);

   logic        busy_ff, busy_in;
   logic        learn_ff, learn_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] peer_ff, peer_in;
   logic [47:0] sha_ff, sha_in;
   logic [31:0] spa_ff, spa_in;
   logic        vld_ff, vld_in;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] lip_ff, lip_in;
   logic [47:0] lmac_ff, lmac_in;
   logic        advance;
   logic [7:0]  rbyte;
   logic [5:0]  rel;

   // reply frame byte at position cnt_ff
   always_comb begin
      rbyte = 8'd0;
      rel   = 6'd0;
      if (cnt_ff < arpr_pkg::POS_PEER_MAC) begin
         rbyte = arpr_pkg::mac_byte(peer_ff, cnt_ff[2:0]);
      end else if (cnt_ff < arpr_pkg::POS_TYPE_HI) begin
         rel   = cnt_ff - arpr_pkg::POS_PEER_MAC;
         rbyte = arpr_pkg::mac_byte(my_mac, rel[2:0]);
      end else if (cnt_ff < arpr_pkg::POS_SHA) begin
         unique case (cnt_ff[4:0])
            5'd12:   rbyte = arpr_pkg::ETHTYPE_HI;
            5'd13:   rbyte = arpr_pkg::ETHTYPE_LO;
            5'd14:   rbyte = arpr_pkg::HTYPE_HI;
            5'd15:   rbyte = arpr_pkg::HTYPE_LO;
            5'd16:   rbyte = arpr_pkg::PTYPE_HI;
            5'd17:   rbyte = arpr_pkg::PTYPE_LO;
            5'd18:   rbyte = arpr_pkg::HLEN;
            5'd19:   rbyte = arpr_pkg::PLEN;
            5'd20:   rbyte = arpr_pkg::OPCODE_HI;
            5'd21:   rbyte = arpr_pkg::OP_REPLY;
            default: rbyte = 8'd0;
         endcase
      end else if (cnt_ff < arpr_pkg::POS_SPA) begin
         rel   = cnt_ff - arpr_pkg::POS_SHA;
         rbyte = arpr_pkg::mac_byte(my_mac, rel[2:0]);
      end else if (cnt_ff < arpr_pkg::POS_THA) begin
         rel   = cnt_ff - arpr_pkg::POS_SPA;
         rbyte = arpr_pkg::ip_byte(my_ip, rel[1:0]);
      end else if (cnt_ff < arpr_pkg::POS_TPA) begin
         rel   = cnt_ff - arpr_pkg::POS_THA;
         rbyte = arpr_pkg::mac_byte(sha_ff, rel[2:0]);
      end else if (cnt_ff < arpr_pkg::POS_END) begin
         rel   = cnt_ff - arpr_pkg::POS_TPA;
         rbyte = arpr_pkg::ip_byte(spa_ff, rel[1:0]);
      end
   end

   // sequencer and output register
   always_comb begin
      advance  = !vld_ff || rsp_ready;
      busy_in  = busy_ff;
      learn_in = learn_ff;
      cnt_in   = cnt_ff;
      peer_in  = peer_ff;
      sha_in   = sha_ff;
      spa_in   = spa_ff;
      vld_in   = vld_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      lip_in   = lip_ff;
      lmac_in  = lmac_ff;

      if (busy_ff && advance) begin
         vld_in = 1'b1;
         if (learn_ff) begin
            kind_in = arpr_pkg::KIND_LEARN;
            byte_in = 8'd0;
            last_in = 1'b1;
            lip_in  = spa_ff;
            lmac_in = sha_ff;
            busy_in = 1'b0;
         end else begin
            kind_in = arpr_pkg::KIND_REPLY;
            byte_in = rbyte;
            last_in = (cnt_ff == arpr_pkg::POS_LAST);
            lip_in  = 32'd0;
            lmac_in = 48'd0;
            if (cnt_ff == arpr_pkg::POS_LAST) begin
               busy_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end

      // new frame-end event, only taken while idle
      if (evt.valid) begin
         busy_in  = 1'b1;
         learn_in = evt.learn;
         cnt_in   = 6'd0;
         peer_in  = evt.peer_mac;
         sha_in   = evt.sha;
         spa_in   = evt.spa;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      learn_ff <= learn_in;
      peer_ff  <= peer_in;
      sha_ff   <= sha_in;
      spa_ff   <= spa_in;
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      lip_ff   <= lip_in;
      lmac_ff  <= lmac_in;
   end

   assign busy            = busy_ff;
   assign rsp_valid       = vld_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_tx_byte     = byte_ff;
   assign rsp_tx_last     = last_ff;
   assign rsp_learned_ip  = lip_ff;
   assign rsp_learned_mac = lmac_ff;

   // events arrive only when the sequencer is free
   a_evt_idle: assert property (@(posedge clock) disable iff (reset)
      evt.valid |-> !busy_ff)
      else $error("event while transmitter busy");

   // reply counter stays inside the frame
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= arpr_pkg::POS_LAST)
      else $error("reply counter out of range");

   // the final reply byte frees the sequencer
   a_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && advance && !learn_ff && cnt_ff == arpr_pkg::POS_LAST |=> !busy_ff && rsp_tx_last)
      else $error("reply did not finish on its last byte");

   // a mapping result carries no reply byte and ends its group
   a_learn: assert property (@(posedge clock) disable iff (reset)
      vld_ff && kind_ff == arpr_pkg::KIND_LEARN |-> byte_ff == 8'd0 && last_ff)
      else $error("malformed mapping result");

endmodule

/* design/arp_responder.sv */
// ARP responder.
// Request channel (req_valid/req_ready): one received Ethernet frame byte per
// request, destination MAC first, req_frame_end on the final byte. Frame
// bytes are taken every cycle; a final byte is held off only while an
// earlier reply or mapping is still being sent.
// Response channel (rsp_valid/rsp_ready): an ARP reply (opcode 2) frame gives
// one mapping response (rsp_kind 1); an ARP request for our IP gives the
// 42-byte reply frame, one byte per response, rsp_tx_last on the last byte.
// The final request byte arms the sequencer, which loads the first response
// into the response register once that register is free; reply bytes then
// follow one per cycle while rsp_ready stays high, until the last byte frees
// the transmitter; a mapping is a single response.
// A stalled receiver holds the response register; the parser keeps taking
// bytes of the next frame meanwhile.
// Configuration (csr_write_enable/csr_index/csr_data): index 0 is my_ip
// (zero disables replies), index 1 is my_mac; write only while idle.
// Reset clears both registers, the parser and the transmitter's busy, valid and byte count.
module arp_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [31:0] rsp_learned_ip,
   output logic [47:0] rsp_learned_mac,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [47:0] csr_data
);

   logic [31:0]         my_ip_ff;
   logic [47:0]         my_mac_ff;
   logic                accept;
   logic                busy;
   arpr_pkg::event_type evt;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         my_ip_ff  <= 32'd0;
         my_mac_ff <= 48'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            arpr_pkg::CSR_MY_IP:  my_ip_ff  <= csr_data[31:0];
            arpr_pkg::CSR_MY_MAC: my_mac_ff <= csr_data;
         endcase
      end
   end

   // only a final byte must wait for the transmitter
   assign req_ready = !(req_frame_end && busy);
   assign accept    = req_valid && req_ready;

   arpr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .frame_end (req_frame_end),
      .my_ip     (my_ip_ff),
      .evt       (evt)
   );

   arpr_tx u_tx (
      .clock           (clock),
      .reset           (reset),
      .evt             (evt),
      .my_ip           (my_ip_ff),
      .my_mac          (my_mac_ff),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_tx_last     (rsp_tx_last),
      .rsp_learned_ip  (rsp_learned_ip),
      .rsp_learned_mac (rsp_learned_mac)
   );

endmodule

/* bench/tb.sv */
module tb;

   localparam int LIMIT_CYCLES = 100000;
   // cycles to let the block settle once nothing more is owed
   localparam int SETTLE = 60;
   localparam int STALL_CYCLES = 300;
   localparam logic [15:0] ARP_TYPE = {arpr_pkg::ETHTYPE_HI, arpr_pkg::ETHTYPE_LO};
   localparam logic [15:0] OPC_REQUEST = {arpr_pkg::OPCODE_HI, arpr_pkg::OP_REQUEST};
   localparam logic [15:0] OPC_REPLY = {arpr_pkg::OPCODE_HI, arpr_pkg::OP_REPLY};

   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   // one received frame byte
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rx_item_type;

   // one response as the block should present it
   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [31:0] ip;
      logic [47:0] mac;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic [31:0] rsp_learned_ip;
   logic [47:0] rsp_learned_mac;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [47:0] csr_data = '0;

   arp_responder u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_learned_ip(rsp_learned_ip),
      .rsp_learned_mac(rsp_learned_mac),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // frame bytes waiting to be offered, and responses the block owes
   rx_item_type  pending_req[$];
   rx_item_type  frame_q[$];
   rsp_item_type owed_rsp[$];

   // shadow of the parser and of the registers
   logic [31:0] cfg_ip = '0;
   logic [47:0] cfg_mac = '0;
   logic [5:0]  pos = '0;
   logic        is_arp = 1'b0;
   logic [7:0]  op_low = '0;
   logic [47:0] peer_mac = '0;
   logic [47:0] sha = '0;
   logic [31:0] spa = '0;
   logic        tgt_me = 1'b1;

   logic req_taken = 1'b0;
   int   idle_pct = 25;
   bit   stall_req = 1'b0;
   bit   stall_done = 1'b0;
   int   stall_left = 0;
   int   cycles = 0;
   int   fault_count = 0;
   int   frames_built = 0;
   int   bytes_accepted = 0;
   int   reply_bytes = 0;
   int   mappings = 0;
   int   csr_writes = 0;

   // advance the shadow parser by one accepted request; queue what it causes
   task automatic arp_rx_byte(input logic [7:0] b, input logic last);
      logic [335:0] frm;
      rsp_item_type r;
      int           i;
      if (pos >= arpr_pkg::POS_PEER_MAC && pos < arpr_pkg::POS_TYPE_HI)
         peer_mac = {peer_mac[39:0], b};
      else if (pos == arpr_pkg::POS_TYPE_HI) is_arp = (b == arpr_pkg::ETHTYPE_HI);
      else if (pos == arpr_pkg::POS_TYPE_LO) is_arp = is_arp && (b == arpr_pkg::ETHTYPE_LO);
      else if (pos == arpr_pkg::POS_OPCODE) op_low = b;
      else if (pos >= arpr_pkg::POS_SHA && pos < arpr_pkg::POS_SPA) sha = {sha[39:0], b};
      else if (pos >= arpr_pkg::POS_SPA && pos < arpr_pkg::POS_THA)
         spa[8*(pos-arpr_pkg::POS_SPA) +: 8] = b;
      else if (pos >= arpr_pkg::POS_TPA && pos < arpr_pkg::POS_END) begin
         if (cfg_ip[8*(pos-arpr_pkg::POS_TPA) +: 8] != b) tgt_me = 1'b0;
      end

      if (!last) begin
         if (pos != arpr_pkg::POS_MAX) pos = pos + 6'd1;
      end else begin
         if (pos >= arpr_pkg::POS_LAST && is_arp) begin
            if (op_low == arpr_pkg::OP_REPLY) begin
               r.kind = arpr_pkg::KIND_LEARN;
               r.tx_byte = '0;
               r.tx_last = 1'b1;
               r.ip = spa;
               r.mac = sha;
               owed_rsp.push_back(r);
            end else if (op_low == arpr_pkg::OP_REQUEST && tgt_me && cfg_ip != '0) begin
               // IPv4 addresses go out low byte first
               frm = {peer_mac, cfg_mac, arpr_pkg::ETHTYPE_HI, arpr_pkg::ETHTYPE_LO,
                      arpr_pkg::HTYPE_HI, arpr_pkg::HTYPE_LO, arpr_pkg::PTYPE_HI,
                      arpr_pkg::PTYPE_LO, arpr_pkg::HLEN, arpr_pkg::PLEN,
                      arpr_pkg::OPCODE_HI, arpr_pkg::OP_REPLY, cfg_mac,
                      cfg_ip[7:0], cfg_ip[15:8], cfg_ip[23:16], cfg_ip[31:24], sha,
                      spa[7:0], spa[15:8], spa[23:16], spa[31:24]};
               for (i = 0; i < int'(arpr_pkg::POS_END); i++) begin
                  r.kind = arpr_pkg::KIND_REPLY;
                  r.tx_byte = frm[335-8*i -: 8];
                  r.tx_last = (i == int'(arpr_pkg::POS_LAST));
                  r.ip = '0;
                  r.mac = '0;
                  owed_rsp.push_back(r);
               end
            end
         end
         pos = '0;
         is_arp = 1'b0;
         tgt_me = 1'b1;
      end
   endtask

   // build one frame into frame_q; header fields override the fill
   task automatic build_frame(input logic [15:0] etype, input logic [15:0] opc,
                              input logic [31:0] tpa, input int len, input fill_type fill);
      logic [7:0]  b;
      rx_item_type it;
      int          i;
      frame_q.delete();
      for (i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default:   b = 8'($urandom_range(255));
         endcase
         if (i == arpr_pkg::POS_TYPE_HI) b = etype[15:8];
         else if (i == arpr_pkg::POS_TYPE_LO) b = etype[7:0];
         else if (i == arpr_pkg::POS_OPCODE - 1) b = opc[15:8];
         else if (i == arpr_pkg::POS_OPCODE) b = opc[7:0];
         else if (i >= arpr_pkg::POS_TPA && i < arpr_pkg::POS_END)
            b = tpa[8*(i-arpr_pkg::POS_TPA) +: 8];
         it.data = b;
         it.last = (i == len - 1);
         frame_q.push_back(it);
      end
      frames_built++;
   endtask

   task automatic push_bytes(input int from, input int upto);
      int i;
      for (i = from; i < upto; i++) pending_req.push_back(frame_q[i]);
   endtask

   task automatic queue_frame(input logic [15:0] etype, input logic [15:0] opc,
                              input logic [31:0] tpa, input int len, input fill_type fill);
      build_frame(etype, opc, tpa, len, fill);
      push_bytes(0, len);
   endtask

   task automatic csr_write(input logic idx, input logic [47:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == arpr_pkg::CSR_MY_IP) cfg_ip = val[31:0];
      else cfg_mac = val;
      csr_writes++;
   endtask

   // wait until every request is taken and every response has come back
   task automatic drain();
      while (pending_req.size() != 0 || req_valid || owed_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : req_driver
      rx_item_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_req.size() != 0 && $urandom_range(99) >= idle_pct) begin
            nxt = pending_req.pop_front();
            req_valid <= 1'b1;
            req_rx_byte <= nxt.data;
            req_frame_end <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready: random gaps, plus one long hold-off on request
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_req && !stall_done) begin
         rsp_ready <= 1'b0;
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= idle_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         arp_rx_byte(req_rx_byte, req_frame_end);
         bytes_accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_rsp.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected response: kind=%0d byte=%02h last=%0d ip=%08h mac=%012h",
                        rsp_kind, rsp_tx_byte, rsp_tx_last, rsp_learned_ip,
                        rsp_learned_mac);
            fault_count++;
         end else begin
            want = owed_rsp.pop_front();
            if (want.kind == arpr_pkg::KIND_LEARN) mappings++;
            else reply_bytes++;
            if (rsp_kind !== want.kind || rsp_tx_byte !== want.tx_byte ||
                rsp_tx_last !== want.tx_last || rsp_learned_ip !== want.ip ||
                rsp_learned_mac !== want.mac) begin
               if (fault_count < 10) begin
                  $display("mismatch exp: kind=%0d byte=%02h last=%0d ip=%08h mac=%012h",
                           want.kind, want.tx_byte, want.tx_last, want.ip, want.mac);
                  $display("         got: kind=%0d byte=%02h last=%0d ip=%08h mac=%012h",
                           rsp_kind, rsp_tx_byte, rsp_tx_last, rsp_learned_ip,
                           rsp_learned_mac);
               end
               fault_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("[arp_responder] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] ip_a;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      ip_a = $urandom;
      if (ip_a == '0) ip_a = 32'h1;
      csr_write(arpr_pkg::CSR_MY_IP, {16'h0, ip_a});
      csr_write(arpr_pkg::CSR_MY_MAC, 48'({$urandom, $urandom}));

      // gap-free start under a long receiver stall: the mapping frame's
      // final byte waits behind the held reply
      idle_pct = 0;
      stall_req = 1'b1;
      queue_frame(ARP_TYPE, {8'hFF, arpr_pkg::OP_REQUEST}, cfg_ip, 42, FILL_RANDOM);
      queue_frame(ARP_TYPE, {8'hA5, arpr_pkg::OP_REPLY}, $urandom, 42, FILL_RANDOM);
      drain();

      // random gaps: last target byte off by one bit, short frame, wrong
      // ethertype, frame running past the saturated position
      idle_pct = 25;
      queue_frame(ARP_TYPE, OPC_REQUEST, cfg_ip ^ 32'h8000_0000, 42, FILL_RANDOM);
      queue_frame(ARP_TYPE, OPC_REQUEST, cfg_ip, 41, FILL_RANDOM);
      queue_frame({arpr_pkg::ETHTYPE_HI, 8'h00}, OPC_REQUEST, cfg_ip, 42, FILL_RANDOM);
      queue_frame(ARP_TYPE, OPC_REQUEST, cfg_ip, 66, FILL_ONES);
      drain();

      // zero own IP: replies off
      csr_write(arpr_pkg::CSR_MY_IP, 48'h0);
      queue_frame(ARP_TYPE, OPC_REQUEST, 32'h0, 42, FILL_ZERO);
      drain();

      if (owed_rsp.size() != 0) begin
         $display("%0d responses never arrived", owed_rsp.size());
         fault_count++;
      end
      $display("covered %0d frames (%0d bytes) over %0d register writes",
               frames_built, bytes_accepted, csr_writes);
      $display("checked %0d reply bytes and %0d learned mappings, %0d faults",
               reply_bytes, mappings, fault_count);
      if (fault_count == 0) $display("[arp_responder] OK");
      else $display("[arp_responder] ERROR");
      $finish;
   end

endmodule
